// ----- rtl/lcst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcst_pkg
// Shared types and constants of the lookup-table code scan with best list.
// ----------------------------------------------------------------------------
package lcst_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CODE  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] REG_ROW_BYTES     = 2'd0;
    localparam logic [1:0] REG_KEEP_COUNT    = 2'd1;
    localparam logic [1:0] REG_HIGHER_BETTER = 2'd2;

    localparam int CODES_PER_POS = 256;
    localparam int SCORE_BITS    = 40;
    localparam int ID_BITS       = 31;
    localparam int CFG_BITS      = 8;

    localparam logic [7:0] ROW_BYTES_RESET  = 8'd96;
    localparam logic [4:0] KEEP_COUNT_RESET = 5'd10;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  table_pos;
        logic [7:0]  code;
        logic signed [31:0] table_value;
        logic [30:0] cand_id;
    } in_item_t;

    typedef struct packed {
        logic [30:0] out_id;
        logic signed [39:0] out_score;
        logic [3:0]  out_rank;
        logic        out_empty;
        logic        out_last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic take;       // register the accepted item
        logic wr_table;   // write the table entry
        logic rd_table;   // read the table entry for a code byte
        logic add;        // add the read entry to the row sum
        logic ins_start;  // begin an insert scan
        logic ins_step;   // compare one list entry
        logic ins_shift;  // shift one list entry down
        logic ins_put;    // place the new candidate
        logic clear;      // empty the list
        logic drn_start;  // begin a drain
        logic drn_step;   // show one list entry
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       row_end;
        logic       scan_done;
        logic       shift_done;
        logic       drain_done;
    } stat_t;

endpackage

// ----- rtl/lcst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcst_ctrl
// Sequencer for one item: table write, list clear, lookup and add, list insert, drain.
// ----------------------------------------------------------------------------
module lcst_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  lcst_pkg::stat_t stat,
    output lcst_pkg::ctrl_t ctrl
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_SHIFT = 3'd5;
    localparam logic [2:0] ST_DRAIN = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.take  = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                case (stat.op)
                    lcst_pkg::OP_WRITE:
                    begin
                        ctrl.wr_table = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    lcst_pkg::OP_CODE:
                    begin
                        ctrl.rd_table = 1'b1;
                        state_next    = ST_READ;
                    end
                    lcst_pkg::OP_DRAIN:
                    begin
                        ctrl.drn_start = 1'b1;
                        state_next     = ST_DRAIN;
                    end
                    default:
                    begin
                        ctrl.clear = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                ctrl.add = 1'b1;
                if (stat.row_end)
                begin
                    ctrl.ins_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                ctrl.ins_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    ctrl.ins_put = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctrl.ins_shift = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                ctrl.drn_step = 1'b1;
                if (stat.drain_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/lcst_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcst_dp
// Datapath: lookup table memory, row accumulator, best list and drain output.
// ----------------------------------------------------------------------------
module lcst_dp
#(
    parameter int MAX_ROW_BYTES = 128,
    parameter int LIST_DEPTH    = 16,
    parameter int ENTRY_BITS    = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lcst_pkg::in_item_t  item,
    input  logic [7:0]          row_bytes,
    input  logic [4:0]          keep_count,
    input  logic                higher_better,
    input  lcst_pkg::ctrl_t     ctrl,
    output lcst_pkg::stat_t     stat,
    output logic                result_valid,
    output lcst_pkg::out_item_t result
);

    localparam int POS_BITS   = $clog2(MAX_ROW_BYTES);
    localparam int DEPTH      = MAX_ROW_BYTES * lcst_pkg::CODES_PER_POS;
    localparam int ADDR_BITS  = POS_BITS + 8;
    localparam int LIDX_BITS  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
    localparam int SB         = lcst_pkg::SCORE_BITS;
    localparam int IB         = lcst_pkg::ID_BITS;

    // table memory
    logic [ENTRY_BITS-1:0] tbl_mem [DEPTH];
    logic [ENTRY_BITS-1:0] rd_data_reg;

    lcst_pkg::in_item_t    item_reg;
    logic signed [SB-1:0]  row_sum_reg;
    logic [POS_BITS:0]     pos_reg;
    logic [SB-1:0]         best_score_reg [LIST_DEPTH];
    logic [IB-1:0]         best_id_reg    [LIST_DEPTH];
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   idx_reg;
    logic [CNT_BITS-1:0]   ins_pos_reg;
    logic                  found_reg;
    logic signed [SB-1:0]  new_score_reg;
    logic [IB-1:0]         new_id_reg;

    logic [POS_BITS:0]     eff_row;
    logic [CNT_BITS-1:0]   eff_keep;
    logic [CNT_BITS-1:0]   eff_count;
    logic [POS_BITS:0]     pos_inc;
    logic signed [SB-1:0]  sum_next;
    logic                  wr_ok;
    logic [LIDX_BITS-1:0]  idx_sel;
    logic [LIDX_BITS-1:0]  idx_prev;
    logic signed [SB-1:0]  cmp_score;
    logic                  beats;

    // effective sizes after clamping
    always_comb
    begin
        if (row_bytes == 8'd0)
        begin
            eff_row = (POS_BITS + 1)'(1);
        end
        else if (32'(row_bytes) > MAX_ROW_BYTES)
        begin
            eff_row = (POS_BITS + 1)'(MAX_ROW_BYTES);
        end
        else
        begin
            eff_row = (POS_BITS + 1)'(row_bytes);
        end
        if (keep_count == 5'd0)
        begin
            eff_keep = CNT_BITS'(1);
        end
        else if (32'(keep_count) > LIST_DEPTH)
        begin
            eff_keep = CNT_BITS'(LIST_DEPTH);
        end
        else
        begin
            eff_keep = CNT_BITS'(keep_count);
        end
        eff_count = (count_reg > eff_keep) ? eff_keep : count_reg;
    end

    assign wr_ok    = (32'(item_reg.table_pos) < MAX_ROW_BYTES);
    assign pos_inc  = pos_reg + 1'b1;
    assign sum_next = row_sum_reg + SB'($signed(rd_data_reg));
    assign idx_sel  = idx_reg[LIDX_BITS-1:0];
    assign idx_prev = LIDX_BITS'(idx_reg - 1'b1);
    assign cmp_score = $signed(best_score_reg[idx_sel]);

    // new candidate against the entry at the scan index
    always_comb
    begin
        if (new_score_reg != cmp_score)
        begin
            beats = higher_better ? (new_score_reg > cmp_score)
                                  : (new_score_reg < cmp_score);
        end
        else
        begin
            beats = (new_id_reg < best_id_reg[idx_sel]);
        end
    end

    assign stat.op         = item_reg.op;
    assign stat.row_end    = (pos_inc >= eff_row);
    assign stat.scan_done  = (idx_reg >= eff_count) || beats || found_reg;
    assign stat.shift_done = found_reg || (idx_reg <= ins_pos_reg);
    assign stat.drain_done = (eff_count == '0) || (idx_reg + 1'b1 >= eff_count);

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_table && wr_ok)
        begin
            tbl_mem[{POS_BITS'(item_reg.table_pos), item_reg.code}] <=
                ENTRY_BITS'(item_reg.table_value);
        end
        if (ctrl.rd_table)
        begin
            rd_data_reg <= tbl_mem[ADDR_BITS'({pos_reg[POS_BITS-1:0], item_reg.code})];
        end
    end

    // item register
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            item_reg <= item;
        end
    end

    // row accumulator, list control and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg   <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            ins_pos_reg   <= '0;
            found_reg     <= 1'b0;
            new_score_reg <= '0;
            new_id_reg    <= '0;
            result_valid  <= 1'b0;
            result        <= '0;
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                best_score_reg[i] <= '0;
                best_id_reg[i]    <= '0;
            end
        end
        else
        begin
            result_valid <= 1'b0;
            if (ctrl.add)
            begin
                if (stat.row_end)
                begin
                    row_sum_reg   <= '0;
                    pos_reg       <= '0;
                    new_score_reg <= sum_next;
                    new_id_reg    <= item_reg.cand_id;
                end
                else
                begin
                    row_sum_reg <= sum_next;
                    pos_reg     <= pos_inc;
                end
            end
            if (ctrl.ins_start)
            begin
                count_reg <= eff_count;
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            // scan stops at the first entry beaten or at the end of the list
            if (ctrl.ins_step)
            begin
                if (stat.scan_done)
                begin
                    ins_pos_reg <= idx_reg;
                    if (idx_reg >= eff_keep)
                    begin
                        found_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= (count_reg < eff_keep) ? count_reg
                                                          : CNT_BITS'(eff_keep - 1'b1);
                        if (count_reg < eff_keep)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            // shift lower entries down one rank
            if (ctrl.ins_shift)
            begin
                best_score_reg[idx_sel] <= best_score_reg[idx_prev];
                best_id_reg[idx_sel]    <= best_id_reg[idx_prev];
                idx_reg                 <= idx_reg - 1'b1;
            end
            if (ctrl.ins_put && !found_reg)
            begin
                best_score_reg[ins_pos_reg[LIDX_BITS-1:0]] <= new_score_reg;
                best_id_reg[ins_pos_reg[LIDX_BITS-1:0]]    <= new_id_reg;
            end
            if (ctrl.clear)
            begin
                count_reg <= '0;
            end
            if (ctrl.drn_start)
            begin
                idx_reg <= '0;
            end
            // drain one rank a cycle
            if (ctrl.drn_step)
            begin
                result_valid <= 1'b1;
                if (eff_count == '0)
                begin
                    result.out_id    <= '0;
                    result.out_score <= '0;
                    result.out_rank  <= '0;
                    result.out_empty <= 1'b1;
                    result.out_last  <= 1'b1;
                end
                else
                begin
                    result.out_id    <= best_id_reg[idx_sel];
                    result.out_score <= best_score_reg[idx_sel];
                    result.out_rank  <= 4'(idx_reg);
                    result.out_empty <= 1'b0;
                    result.out_last  <= stat.drain_done;
                    idx_reg          <= idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/lut_code_scan_topk_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_code_scan_topk_top
// Lookup-table code scan of quantized rows with a sorted best list.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the cycle after start until the item
// is done. A table write or clear ends after its decode, a code byte reads the
// table and adds the entry to the row sum, and the byte that ends a row adds
// an insert (a scan over the list one entry a cycle, then a shift one entry a
// cycle). A drain shows the results in rank order, each result held on the
// result ports for one cycle under result_valid; the receiver cannot stall.
// The table memory has no reset: an entry must be written before it is read.
module lut_code_scan_topk_top
#(
    parameter int MAX_ROW_BYTES = 128,
    parameter int LIST_DEPTH    = 16,
    parameter int ENTRY_BITS    = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lcst_pkg::in_item_t          item,
    output logic                        result_valid,
    output lcst_pkg::out_item_t         result,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [lcst_pkg::CFG_BITS-1:0] cfg_data
);

    logic [7:0]      row_bytes_reg;
    logic [4:0]      keep_count_reg;
    logic            higher_better_reg;
    lcst_pkg::ctrl_t ctrl;
    lcst_pkg::stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg     <= lcst_pkg::ROW_BYTES_RESET;
            keep_count_reg    <= lcst_pkg::KEEP_COUNT_RESET;
            higher_better_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcst_pkg::REG_ROW_BYTES:     row_bytes_reg     <= cfg_data;
                lcst_pkg::REG_KEEP_COUNT:    keep_count_reg    <= cfg_data[4:0];
                lcst_pkg::REG_HIGHER_BETTER: higher_better_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    lcst_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    lcst_dp
    #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .LIST_DEPTH    (LIST_DEPTH),
        .ENTRY_BITS    (ENTRY_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .row_bytes     (row_bytes_reg),
        .keep_count    (keep_count_reg),
        .higher_better (higher_better_reg),
        .ctrl          (ctrl),
        .stat          (stat),
        .result_valid  (result_valid),
        .result        (result)
    );

`ifndef NO_ASSERTIONS
    // a result only appears while an item is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without an item in work");

    // an empty result is always the last of its drain
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_empty |-> result.out_last)
        else $error("empty result not marked last");

    // after the last result the block goes idle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_last |-> !busy)
        else $error("busy after last drain result");
`endif

endmodule
